>>> hw/rtl/dbpc_pkg.sv
// ----------------------------------------------------------------------------
// dbpc_pkg
// Shared types and constants of the dual button press classifier.
// ----------------------------------------------------------------------------
package dbpc_pkg;

   localparam int HOLD_W      = 26;
   localparam int DEBOUNCE_W  = 20;
   localparam int CSR_DATA_W  = 26;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_HOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_HOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE   = 2'd2;

   localparam logic [HOLD_W-1:0]     BOOT_HOLD_RESET  = 26'd3000000;
   localparam logic [HOLD_W-1:0]     POWER_HOLD_RESET = 26'd2000000;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 20'd30000;

   typedef struct packed {
      logic short_ev;
      logic long_ev;
   } press_event_type;

endpackage

>>> hw/rtl/dbpc_if.sv
// ----------------------------------------------------------------------------
// dbpc_if
// Request and response channels of the dual button press classifier.
// ----------------------------------------------------------------------------
interface dbpc_req_if #(
   parameter int TIME_BITS = 48
);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] now_us;
   logic                 boot_pressed;
   logic                 power_pressed;

   modport source (output valid, output now_us, output boot_pressed,
                   output power_pressed, input ready);
   modport sink   (input valid, input now_us, input boot_pressed,
                   input power_pressed, output ready);
endinterface

interface dbpc_rsp_if;
   logic valid;
   logic ready;
   logic boot_short;
   logic boot_long;
   logic power_short;
   logic power_long;
   logic battery_enable;

   modport source (output valid, output boot_short, output boot_long,
                   output power_short, output power_long,
                   output battery_enable, input ready);
   modport sink   (input valid, input boot_short, input boot_long,
                   input power_short, input power_long,
                   input battery_enable, output ready);
endinterface

>>> hw/rtl/dbpc_lane.sv
// ----------------------------------------------------------------------------
// dbpc_lane
// Per-button press tracker: start time, held and fired marks, event detect.
// ----------------------------------------------------------------------------
module dbpc_lane
   import dbpc_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [TIME_BITS-1:0]  now_us,
   input  logic                  pressed,
   input  logic [HOLD_W-1:0]     hold_us,
   input  logic [DEBOUNCE_W-1:0] debounce_us,
   output press_event_type       press_event
);

   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic                 held_ff, held_in;
   logic                 fired_ff, fired_in;

   logic                 start;
   logic                 fired_eff;
   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_BITS-1:0] hold_ext;
   logic [TIME_BITS-1:0] debounce_ext;

   assign hold_ext     = {{(TIME_BITS-HOLD_W){1'b0}}, hold_us};
   assign debounce_ext = {{(TIME_BITS-DEBOUNCE_W){1'b0}}, debounce_us};

   always_comb begin
      start     = pressed && !held_ff;
      fired_eff = fired_ff && !start;
      elapsed   = start ? '0 : (now_us - press_start_ff);

      press_event.long_ev  = pressed && !fired_eff && (elapsed >= hold_ext);
      press_event.short_ev = !pressed && held_ff && !fired_ff && (elapsed > debounce_ext);

      held_in        = held_ff;
      fired_in       = fired_ff;
      press_start_in = press_start_ff;
      if (step) begin
         held_in = pressed;
         if (start) begin
            press_start_in = now_us;
         end
         if (pressed) begin
            fired_in = fired_eff || press_event.long_ev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         fired_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         fired_ff <= fired_in;
      end
      press_start_ff <= press_start_in;
   end

endmodule

>>> hw/rtl/dbpc_merge.sv
// ----------------------------------------------------------------------------
// dbpc_merge
// Combines lane events, latches power-off and holds the response register.
// ----------------------------------------------------------------------------
module dbpc_merge
   import dbpc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  press_event_type boot_event,
   input  press_event_type power_event,
   output logic            live,
   output logic            ready,
   dbpc_rsp_if.source      rsp
);

   logic            powered_down_ff, powered_down_in;
   logic            rsp_valid_ff, rsp_valid_in;
   press_event_type boot_ff, boot_in;
   press_event_type power_ff, power_in;
   logic            battery_ff, battery_in;

   assign live  = !powered_down_ff;
   assign ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      powered_down_in = powered_down_ff;
      rsp_valid_in    = rsp_valid_ff;
      boot_in         = boot_ff;
      power_in        = power_ff;
      battery_in      = battery_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (powered_down_ff) begin
            boot_in    = '0;
            power_in   = '0;
            battery_in = 1'b0;
         end else begin
            boot_in         = boot_event;
            power_in        = power_event;
            battery_in      = !power_event.long_ev;
            powered_down_in = power_event.long_ev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         powered_down_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         powered_down_ff <= powered_down_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      boot_ff    <= boot_in;
      power_ff   <= power_in;
      battery_ff <= battery_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.boot_short     = boot_ff.short_ev;
   assign rsp.boot_long      = boot_ff.long_ev;
   assign rsp.power_short    = power_ff.short_ev;
   assign rsp.power_long     = power_ff.long_ev;
   assign rsp.battery_enable = battery_ff;

endmodule

>>> hw/rtl/dual_button_press_classifier.sv
// ----------------------------------------------------------------------------
// dual_button_press_classifier
// Classifies boot and power button presses into short and long events.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one poll per request: now_us and both pressed bits.
//   rsp_bus returns exactly one response per request: four event bits and
//   battery_enable. csr_* writes the hold and debounce times while idle.
//   The response is registered: it is shown in the cycle after its request is accepted.
//   Throughput is one request per cycle while responses are taken; the two button lanes evaluate in
//   parallel and a single response register sets the pace.
//   When the receiver stalls, the response register holds and req_bus.ready
//   drops until it is taken (ready = response slot empty or being taken).
//   Reset clears the press marks, the power-off latch and the response slot
//   and restores the default hold and debounce times. After a power long
//   event every later response is all zero until reset.
// ----------------------------------------------------------------------------
module dual_button_press_classifier
   import dbpc_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   dbpc_req_if.sink               req_bus,
   dbpc_rsp_if.source             rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [HOLD_W-1:0]     boot_hold_ff, boot_hold_in;
   logic [HOLD_W-1:0]     power_hold_ff, power_hold_in;
   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;

   logic            accept;
   logic            live;
   logic            step;
   logic            ready;
   press_event_type boot_event;
   press_event_type power_event;

   always_comb begin
      boot_hold_in  = boot_hold_ff;
      power_hold_in = power_hold_ff;
      debounce_in   = debounce_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BOOT_HOLD:  boot_hold_in  = csr_write_data[HOLD_W-1:0];
            CSR_POWER_HOLD: power_hold_in = csr_write_data[HOLD_W-1:0];
            CSR_DEBOUNCE:   debounce_in   = csr_write_data[DEBOUNCE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_hold_ff  <= BOOT_HOLD_RESET;
         power_hold_ff <= POWER_HOLD_RESET;
         debounce_ff   <= DEBOUNCE_RESET;
      end else begin
         boot_hold_ff  <= boot_hold_in;
         power_hold_ff <= power_hold_in;
         debounce_ff   <= debounce_in;
      end
   end

   assign req_bus.ready = ready;
   assign accept        = req_bus.valid && ready;
   assign step          = accept && live;

   dbpc_lane #(.TIME_BITS(TIME_BITS)) u_boot_lane (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .now_us      (req_bus.now_us),
      .pressed     (req_bus.boot_pressed),
      .hold_us     (boot_hold_ff),
      .debounce_us (debounce_ff),
      .press_event (boot_event)
   );

   dbpc_lane #(.TIME_BITS(TIME_BITS)) u_power_lane (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .now_us      (req_bus.now_us),
      .pressed     (req_bus.power_pressed),
      .hold_us     (power_hold_ff),
      .debounce_us (debounce_ff),
      .press_event (power_event)
   );

   dbpc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .boot_event  (boot_event),
      .power_event (power_event),
      .live        (live),
      .ready       (ready),
      .rsp         (rsp_bus)
   );

endmodule

>>> hw/rtl/dbpc_checker.sv
// ----------------------------------------------------------------------------
// dbpc_checker
// Port-level checks of the dual button press classifier.
// ----------------------------------------------------------------------------
module dbpc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_boot_short,
   input logic rsp_boot_long,
   input logic rsp_power_short,
   input logic rsp_power_long,
   input logic rsp_battery_enable
);

   logic off_seen_ff, off_seen_in;

   assign off_seen_in = off_seen_ff || (rsp_valid && rsp_ready && !rsp_battery_enable);

   always_ff @(posedge clock) begin
      if (reset) begin
         off_seen_ff <= 1'b0;
      end else begin
         off_seen_ff <= off_seen_in;
      end
   end

   a_silent_after_off: assert property (@(posedge clock) disable iff (reset)
      off_seen_ff && rsp_valid |-> !rsp_battery_enable && !rsp_boot_short
         && !rsp_boot_long && !rsp_power_short && !rsp_power_long)
      else $error("response after power-off is not silent");

   a_power_long_drops_battery: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_long |-> !rsp_battery_enable)
      else $error("power long event with battery still enabled");

   a_short_long_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_boot_short && rsp_boot_long)
         && !(rsp_power_short && rsp_power_long))
      else $error("short and long event on the same button");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_battery_enable)
         && $stable(rsp_power_long) && $stable(rsp_boot_long))
      else $error("stalled response changed");

endmodule

bind dual_button_press_classifier dbpc_checker u_dbpc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_boot_short     (rsp_bus.boot_short),
   .rsp_boot_long      (rsp_bus.boot_long),
   .rsp_power_short    (rsp_bus.power_short),
   .rsp_power_long     (rsp_bus.power_long),
   .rsp_battery_enable (rsp_bus.battery_enable)
);

>>> tb/sv/tb_dual_button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_button_press_classifier
// Self-checking bench for the boot and power button press classifier.
// A table of hand-picked polls runs first, each with its result typed in or
// left to the predictor. Random polls follow under several hold and debounce
// settings, aimed at exact boundaries and at time wrap, with random idling
// on both channels. The run ends with the power-off latch and the silent
// polls behind it.
// ----------------------------------------------------------------------------
module tb_dual_button_press_classifier;
   import dbpc_pkg::*;

   localparam int TIME_BITS       = 48;
   localparam int RESET_CYCLES    = 10;
   localparam int PHASES          = 8;
   localparam int POLLS_PER_PHASE = 240;
   localparam int SILENT_POLLS    = 12;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int STALL_LIMIT     = 4000;
   localparam int REPORT_LIMIT    = 10;
   localparam int IDLE_PERCENT    = 6;
   localparam int FLIP_PERCENT    = 30;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [HOLD_W-1:0]      HOLD_MAX     = '1;
   localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_MAX = '1;

   typedef struct packed {
      press_event_type boot_ev;
      press_event_type power_ev;
      logic            battery_enable;
   } poll_result_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] now_off;
      logic                 boot;
      logic                 power;
      logic                 typed;
      poll_result_type      want;
   } poll_row_type;

   // result bits: boot short, boot long _ power short, power long _ battery
   localparam poll_row_type OPENING_ROWS [18] = '{
      '{48'd0,               1'b0, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd100,             1'b1, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd30101,           1'b0, 1'b0, 1'b1, 5'b10_00_1},
      '{48'd40000,           1'b1, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd70000,           1'b0, 1'b0, 1'b1, 5'b00_00_1},
      '{48'hFFFF_FFFF_FC18,  1'b1, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd2998999,         1'b1, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd2999000,         1'b1, 1'b0, 1'b1, 5'b01_00_1},
      '{48'd2999001,         1'b1, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd5000000,         1'b0, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd6000000,         1'b0, 1'b1, 1'b1, 5'b00_00_1},
      '{48'd6030001,         1'b0, 1'b0, 1'b1, 5'b00_10_1},
      '{48'd7000000,         1'b0, 1'b1, 1'b1, 5'b00_00_1},
      '{48'd8999999,         1'b0, 1'b1, 1'b1, 5'b00_00_1},
      '{48'd9000000,         1'b0, 1'b0, 1'b1, 5'b00_10_1},
      '{48'hFFFF_FFFF_FFFF,  1'b1, 1'b1, 1'b0, 5'b00_00_0},
      '{48'd0,               1'b1, 1'b1, 1'b0, 5'b00_00_0},
      '{48'h0000_0001_0000,  1'b0, 1'b0, 1'b0, 5'b00_00_0}
   };

   // offsets from a base time; all hold and debounce times are zero here
   localparam poll_row_type CLOSING_ROWS [5] = '{
      '{48'd0, 1'b1, 1'b0, 1'b1, 5'b01_00_1},
      '{48'd5, 1'b0, 1'b0, 1'b1, 5'b00_00_1},
      '{48'd6, 1'b1, 1'b1, 1'b1, 5'b01_01_0},
      '{48'd7, 1'b0, 1'b0, 1'b1, 5'b00_00_0},
      '{48'd8, 1'b1, 1'b1, 1'b1, 5'b00_00_0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   dbpc_req_if #(.TIME_BITS(TIME_BITS)) req_bus ();
   dbpc_rsp_if                          rsp_bus ();

   logic            poll_typed;
   poll_result_type poll_typed_result;

   logic [HOLD_W-1:0]     boot_hold_cfg;
   logic [HOLD_W-1:0]     power_hold_cfg;
   logic [DEBOUNCE_W-1:0] debounce_cfg;
   logic [TIME_BITS-1:0]  press_origin [2];
   logic                  mark_held [2];
   logic                  mark_fired [2];
   logic                  powered_down;

   poll_result_type awaited_results [$];
   poll_result_type seen_result;
   poll_result_type want_result;
   int              fault_count;
   int              stalled_cycles;

   logic                 idling_off;
   logic                 rsp_hold_off;
   logic [TIME_BITS-1:0] drive_now;
   logic                 drive_boot;
   logic                 drive_power;
   logic [TIME_BITS-1:0] drive_boot_origin;
   logic [TIME_BITS-1:0] drive_power_origin;

   dual_button_press_classifier #(.TIME_BITS(TIME_BITS)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic press_event_type step_button(input int idx, input logic pressed,
                                                    input logic [TIME_BITS-1:0] now,
                                                    input logic [HOLD_W-1:0] hold);
      press_event_type      ev;
      logic [TIME_BITS-1:0] elapsed;
      ev = '0;
      if (pressed && !mark_held[idx]) begin
         mark_held[idx]    = 1'b1;
         press_origin[idx] = now;
         mark_fired[idx]   = 1'b0;
      end
      elapsed = now - press_origin[idx];
      if (pressed && !mark_fired[idx] && elapsed >= TIME_BITS'(hold)) begin
         mark_fired[idx] = 1'b1;
         ev.long_ev      = 1'b1;
      end
      if (!pressed && mark_held[idx]) begin
         if (!mark_fired[idx] && elapsed > TIME_BITS'(debounce_cfg)) ev.short_ev = 1'b1;
         mark_held[idx] = 1'b0;
      end
      return ev;
   endfunction

   function automatic poll_result_type classify_poll(input logic [TIME_BITS-1:0] now,
                                                     input logic boot, input logic power);
      poll_result_type r;
      r = '0;
      if (!powered_down) begin
         r.boot_ev  = step_button(0, boot, now, boot_hold_cfg);
         r.power_ev = step_button(1, power, now, power_hold_cfg);
         if (r.power_ev.long_ev) powered_down = 1'b1;
         r.battery_enable = !powered_down;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_result = '{'{rsp_bus.boot_short, rsp_bus.boot_long},
                            '{rsp_bus.power_short, rsp_bus.power_long},
                            rsp_bus.battery_enable};
            if (awaited_results.size() == 0) begin
               if (fault_count < REPORT_LIMIT)
                  $display("unexpected response %b at %0t", seen_result, $realtime);
               fault_count++;
            end else begin
               want_result = awaited_results.pop_front();
               if (seen_result !== want_result) begin
                  if (fault_count < REPORT_LIMIT)
                     $display("mismatch at %0t: expected %b%b%b%b%b actual %b%b%b%b%b",
                              $realtime,
                              want_result.boot_ev.short_ev, want_result.boot_ev.long_ev,
                              want_result.power_ev.short_ev, want_result.power_ev.long_ev,
                              want_result.battery_enable,
                              seen_result.boot_ev.short_ev, seen_result.boot_ev.long_ev,
                              seen_result.power_ev.short_ev, seen_result.power_ev.long_ev,
                              seen_result.battery_enable);
                  fault_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want_result = classify_poll(req_bus.now_us, req_bus.boot_pressed,
                                        req_bus.power_pressed);
            awaited_results.push_back(poll_typed ? poll_typed_result : want_result);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
            rsp_hold_off = 1'b0;
         end else begin
            rsp_bus.ready <= idling_off || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic restore_defaults();
      boot_hold_cfg  = BOOT_HOLD_RESET;
      power_hold_cfg = POWER_HOLD_RESET;
      debounce_cfg   = DEBOUNCE_RESET;
      for (int i = 0; i < 2; i++) begin
         press_origin[i] = '0;
         mark_held[i]    = 1'b0;
         mark_fired[i]   = 1'b0;
      end
      powered_down = 1'b0;
   endtask

   task automatic write_timing(input logic [HOLD_W-1:0] boot_hold,
                               input logic [HOLD_W-1:0] power_hold,
                               input logic [DEBOUNCE_W-1:0] debounce);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BOOT_HOLD;
      csr_write_data   <= boot_hold;
      @(posedge clock);
      csr_index      <= CSR_POWER_HOLD;
      csr_write_data <= power_hold;
      @(posedge clock);
      csr_index      <= CSR_DEBOUNCE;
      csr_write_data <= {(CSR_DATA_W - DEBOUNCE_W)'($urandom()), debounce};
      @(posedge clock);
      csr_index      <= CSR_UNUSED;
      csr_write_data <= CSR_DATA_W'($urandom());
      @(posedge clock);
      csr_write_enable <= 1'b0;
      boot_hold_cfg  = boot_hold;
      power_hold_cfg = power_hold;
      debounce_cfg   = debounce;
   endtask

   task automatic settle_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic offer_poll(input logic [TIME_BITS-1:0] now, input logic boot,
                             input logic power, input logic typed,
                             input poll_result_type want);
      if (!idling_off) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid         <= 1'b1;
      req_bus.now_us        <= now;
      req_bus.boot_pressed  <= boot;
      req_bus.power_pressed <= power;
      poll_typed            <= typed;
      poll_typed_result     <= want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic next_random_poll();
      logic [31:0]          span;
      int                   pick;
      logic                 boot_was;
      logic                 power_was;
      logic [TIME_BITS-1:0] aim;
      span = 32'(boot_hold_cfg);
      if (32'(power_hold_cfg) > span) span = 32'(power_hold_cfg);
      if (32'(debounce_cfg) > span) span = 32'(debounce_cfg);
      span = (span >> 2) + 32'd16;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         drive_now = drive_now + TIME_BITS'($urandom_range(0, 2));
      end else if (pick < 55) begin
         drive_now = drive_now + TIME_BITS'($urandom_range(0, span));
      end else if (pick < 75) begin
         drive_now = drive_now + TIME_BITS'($urandom_range(0, 4 * span));
      end else if (pick < 80) begin
         drive_now = {16'($urandom()), 32'($urandom())};
      end else if (pick < 90) begin
         aim = $urandom_range(0, 1) ? TIME_BITS'(boot_hold_cfg) : TIME_BITS'(debounce_cfg);
         drive_now = drive_boot_origin + aim + TIME_BITS'($urandom_range(0, 2)) - 1;
      end else begin
         aim = $urandom_range(0, 1) ? TIME_BITS'(power_hold_cfg) : TIME_BITS'(debounce_cfg);
         drive_now = drive_power_origin + aim + TIME_BITS'($urandom_range(0, 2)) - 1;
      end
      boot_was  = drive_boot;
      power_was = drive_power;
      if ($urandom_range(0, 99) < FLIP_PERCENT) drive_boot = !drive_boot;
      if ($urandom_range(0, 99) < FLIP_PERCENT) drive_power = !drive_power;
      // drop power before its hold time runs out; power-off waits for the end
      if (drive_power && power_was &&
          (drive_now - drive_power_origin) >= TIME_BITS'(power_hold_cfg))
         drive_power = 1'b0;
      if (drive_boot && !boot_was) drive_boot_origin = drive_now;
      if (drive_power && !power_was) drive_power_origin = drive_now;
      offer_poll(drive_now, drive_boot, drive_power, 1'b0, '0);
   endtask

   initial begin
      poll_row_type         row;
      logic [TIME_BITS-1:0] base;
      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_BOOT_HOLD;
      csr_write_data        <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.now_us        <= '0;
      req_bus.boot_pressed  <= 1'b0;
      req_bus.power_pressed <= 1'b0;
      poll_typed            <= 1'b0;
      poll_typed_result     <= '0;
      idling_off         = 1'b0;
      rsp_hold_off       = 1'b0;
      fault_count        = 0;
      drive_boot         = 1'b0;
      drive_power        = 1'b0;
      drive_boot_origin  = '0;
      drive_power_origin = '0;
      restore_defaults();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_ROWS[i]) begin
         row = OPENING_ROWS[i];
         offer_poll(row.now_off, row.boot, row.power, row.typed, row.want);
      end
      drive_now = OPENING_ROWS[17].now_off;

      for (int phase = 1; phase <= PHASES; phase++) begin
         settle_responses();
         case (phase)
            1: write_timing('0, HOLD_MAX, '0);
            2: write_timing(HOLD_MAX, HOLD_W'(1), DEBOUNCE_MAX);
            default: write_timing(HOLD_W'($urandom_range(0, 4000)),
                                  HOLD_W'($urandom_range(1, 4000)),
                                  DEBOUNCE_W'($urandom_range(0, 2000)));
         endcase
         idling_off = (phase == 3);
         for (int n = 0; n < POLLS_PER_PHASE; n++) begin
            if (phase == 4 && n == 60) rsp_hold_off = 1'b1;
            if (phase == 4 && n == 150) settle_responses();
            next_random_poll();
         end
         drive_boot  = 1'b0;
         drive_power = 1'b0;
         offer_poll(drive_now, 1'b0, 1'b0, 1'b0, '0);
      end

      // zero hold times: latch power-off, then poll the silent block
      settle_responses();
      write_timing('0, '0, '0);
      base = drive_now + 1000;
      foreach (CLOSING_ROWS[i]) begin
         row = CLOSING_ROWS[i];
         offer_poll(base + row.now_off, row.boot, row.power, row.typed, row.want);
      end
      repeat (SILENT_POLLS)
         offer_poll({16'($urandom()), 32'($urandom())}, 1'($urandom()), 1'($urandom()),
                    1'b0, '0);
      settle_responses();

      if (fault_count == 0 && awaited_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
